/* hw/rtl/rrbm_pkg.sv */
// Package for the ROM/RAM bank mapper: field widths, codes, sequencer states
// and the structs passed between the decoder and the top level.
// No dependencies.
package rrbm_pkg;

  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int PHYS_W      = 21;
  localparam int ROM_BANK_W  = 7;
  localparam int RAM_BANK_W  = 2;
  localparam int LOW_SEL_W   = 5;
  localparam int HIGH_SEL_W  = 2;
  localparam int ROM_CNT_W   = 8;
  localparam int RAM_CNT_W   = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int ROM_OFS_W   = 14;
  localparam int RAM_OFS_W   = 13;

  localparam int DVD_W       = 7;
  localparam int DIV_W       = 8;
  localparam int DIV_STEPS   = DVD_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  localparam logic [ROM_CNT_W-1:0] MAX_ROM_BANKS   = 8'd128;
  localparam logic [RAM_CNT_W-1:0] MAX_RAM_BANKS   = 3'd4;
  localparam logic [ROM_CNT_W-1:0] SMALL_ROM_BANKS = 8'd32;
  localparam logic [RAM_CNT_W-1:0] SMALL_RAM_BANKS = 3'd1;
  localparam logic [3:0]           RAM_EN_KEY      = 4'hA;

  localparam logic [ROM_CNT_W-1:0] ROM_CNT_RESET = 8'd2;
  localparam logic [RAM_CNT_W-1:0] RAM_CNT_RESET = 3'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROM_BANK_COUNT = 2'd0,
    CFG_RAM_BANK_COUNT = 2'd1,
    CFG_RAM_PRESENT    = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    TGT_ROM  = 2'd0,
    TGT_RAM  = 2'd1,
    TGT_OPEN = 2'd2
  } target_t;

  typedef enum logic [2:0] {
    REG_NONE,
    REG_RAM_EN,
    REG_LOW,
    REG_HIGH,
    REG_MODE
  } reg_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SW_GO,
    ST_SW_WAIT,
    ST_FX_GO,
    ST_FX_WAIT,
    ST_RB_GO,
    ST_RB_WAIT
  } state_t;

  typedef struct packed {
    target_t             target;
    logic [PHYS_W-1:0]   phys;
    logic                wr;
    logic [DATA_W-1:0]   wdata;
  } map_res_t;

  typedef struct packed {
    logic [ROM_BANK_W-1:0] fixed_bank;
    logic [ROM_BANK_W-1:0] switch_bank;
    logic [RAM_BANK_W-1:0] ram_bank;
    logic                  ram_ok;
  } bank_state_t;

endpackage

/* hw/rtl/rrbm_mod_unit.sv */
// Shared remainder unit: restoring division, one quotient bit per cycle.
// Depends on rrbm_pkg.
module rrbm_mod_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rrbm_pkg::DVD_W-1:0] dividend,
  input  logic [rrbm_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [rrbm_pkg::DVD_W-1:0] remainder
);
  import rrbm_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     rem;
  logic [DVD_W-1:0]     dvd;
  logic [DIV_W-1:0]     div;
  logic [DIV_W-1:0]     trial;

  // The partial remainder stays below the divisor, so its top bit is clear.
  assign trial = {rem[DIV_W-2:0], dvd[DVD_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      div <= divisor;
    end else if (busy) begin
      rem <= (trial >= div) ? trial - div : trial;
      dvd <= {dvd[DVD_W-2:0], 1'b0};
    end
  end

  assign remainder = rem[DVD_W-1:0];

endmodule

/* hw/rtl/rrbm_decode.sv */
// Address decoder: maps one bus access to a target and physical address and
// names the bank register that a write selects. Depends on rrbm_pkg.
module rrbm_decode (
  input  logic                        op,
  input  logic [rrbm_pkg::ADDR_W-1:0] bus_address,
  input  logic [rrbm_pkg::DATA_W-1:0] write_data,
  input  rrbm_pkg::bank_state_t       banks,
  output rrbm_pkg::map_res_t          res,
  output rrbm_pkg::reg_sel_t          reg_sel
);
  import rrbm_pkg::*;

  logic ram_window;

  assign ram_window = (bus_address[15:13] == 3'b101) && banks.ram_ok;

  always_comb begin
    res.target = TGT_OPEN;
    res.phys   = '0;
    res.wr     = 1'b0;
    res.wdata  = '0;
    reg_sel    = REG_NONE;
    if (!op) begin
      priority if (bus_address[15:14] == 2'b00) begin
        res.target = TGT_ROM;
        res.phys   = {banks.fixed_bank, bus_address[ROM_OFS_W-1:0]};
      end else if (bus_address[15:14] == 2'b01) begin
        res.target = TGT_ROM;
        res.phys   = {banks.switch_bank, bus_address[ROM_OFS_W-1:0]};
      end else if (ram_window) begin
        res.target = TGT_RAM;
        res.phys   = {6'd0, banks.ram_bank, bus_address[RAM_OFS_W-1:0]};
      end else begin
        res.target = TGT_OPEN;
      end
    end else begin
      priority if (bus_address[15] == 1'b0) begin
        unique case (bus_address[14:13])
          2'b00: reg_sel = REG_RAM_EN;
          2'b01: reg_sel = REG_LOW;
          2'b10: reg_sel = REG_HIGH;
          default: reg_sel = REG_MODE;
        endcase
      end else if (ram_window) begin
        res.target = TGT_RAM;
        res.phys   = {6'd0, banks.ram_bank, bus_address[RAM_OFS_W-1:0]};
        res.wr     = 1'b1;
        res.wdata  = write_data;
      end else begin
        res.target = TGT_OPEN;
      end
    end
  end

endmodule

/* hw/rtl/rom_ram_bank_mapper.sv */
// Cartridge ROM/RAM bank mapper (top level).
// Depends on rrbm_pkg, rrbm_decode and rrbm_mod_unit.
//
// Usage: each word on the s_ channel is one CPU bus access; s_tuser is the
// access kind (0 read, 1 write). Each access gives exactly one result word on
// the m_ channel with the ROM, RAM or open-bus target in m_tuser and the
// physical address and RAM store request in m_tdata.
// The result is registered at acceptance and is valid on the next cycle.
// A write to the low bank, high bank or an honored mode register starts a
// bank recompute on one shared restoring-division unit: first the
// switchable ROM bank, then the fixed ROM bank in advanced mode and then
// the RAM bank when RAM is also present, so such a write holds off the next
// word until the recompute ends; other accesses start no recompute.
// The block takes a word only while no recompute runs and the output
// register is empty or being read, so a stalled receiver holds its word and
// stops input. Reset clears the bank registers to their power-on values and
// the configuration to 2 ROM banks, 1 RAM bank, no RAM. Configuration is
// written through cfg_we/cfg_index/cfg_wdata and takes effect at the next
// bank recompute and the next access.
module rom_ram_bank_mapper (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [15:0] bus_address, [23:16] write_data
  input  logic [23:0]                     s_tdata,
  // [0] op
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [20:0] physical_address, [21] ram_write, [29:22] ram_write_data
  output logic [31:0]                     m_tdata,
  // [1:0] target
  output logic [1:0]                      m_tuser,
  input  logic                            cfg_we,
  input  logic [rrbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrbm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rrbm_pkg::*;

  logic [ROM_CNT_W-1:0]  rom_bank_count;
  logic [RAM_CNT_W-1:0]  ram_bank_count;
  logic                  ram_present;

  logic                  ram_enabled;
  logic [LOW_SEL_W-1:0]  low_bank_select;
  logic [HIGH_SEL_W-1:0] high_bank_select;
  logic                  advanced_mode;
  logic [ROM_BANK_W-1:0] fixed_area_bank;
  logic [ROM_BANK_W-1:0] switch_area_bank;
  logic [RAM_BANK_W-1:0] ram_bank;

  state_t state, state_next;

  logic                  accept;
  logic                  mode_ignored;
  logic                  recompute;
  logic [ROM_CNT_W-1:0]  roms;
  logic [RAM_CNT_W-1:0]  rams;
  logic [LOW_SEL_W-1:0]  low_new;

  bank_state_t           banks;
  map_res_t              res;
  reg_sel_t              reg_sel;

  logic                  div_start;
  logic [DVD_W-1:0]      div_dividend;
  logic [DIV_W-1:0]      div_divisor;
  logic                  div_done;
  logic [DVD_W-1:0]      div_rem;

  target_t               out_target;
  logic [PHYS_W-1:0]     out_phys;
  logic                  out_wr;
  logic [DATA_W-1:0]     out_wdata;

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign banks.fixed_bank  = fixed_area_bank;
  assign banks.switch_bank = switch_area_bank;
  assign banks.ram_bank    = ram_bank;
  assign banks.ram_ok      = ram_present && ram_enabled;

  rrbm_decode u_decode (
    .op          (s_tuser),
    .bus_address (s_tdata[ADDR_W-1:0]),
    .write_data  (s_tdata[ADDR_W+DATA_W-1:ADDR_W]),
    .banks       (banks),
    .res         (res),
    .reg_sel     (reg_sel)
  );

  rrbm_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign mode_ignored = (rom_bank_count <= SMALL_ROM_BANKS) &&
                        (ram_bank_count <= SMALL_RAM_BANKS);
  assign recompute = (reg_sel == REG_LOW) || (reg_sel == REG_HIGH) ||
                     ((reg_sel == REG_MODE) && !mode_ignored);

  assign roms = (rom_bank_count == '0) ? ROM_CNT_W'(1) :
                (rom_bank_count > MAX_ROM_BANKS) ? MAX_ROM_BANKS : rom_bank_count;
  assign rams = (ram_bank_count == '0) ? RAM_CNT_W'(1) :
                (ram_bank_count > MAX_RAM_BANKS) ? MAX_RAM_BANKS : ram_bank_count;

  assign low_new = (s_tdata[ADDR_W+LOW_SEL_W-1:ADDR_W] == '0) ? LOW_SEL_W'(1) :
                   s_tdata[ADDR_W+LOW_SEL_W-1:ADDR_W];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (accept && recompute) state_next = ST_SW_GO;
      ST_SW_GO:   state_next = ST_SW_WAIT;
      ST_SW_WAIT: if (div_done) state_next = advanced_mode ? ST_FX_GO : ST_IDLE;
      ST_FX_GO:   state_next = ST_FX_WAIT;
      ST_FX_WAIT: if (div_done) state_next = ram_present ? ST_RB_GO : ST_IDLE;
      ST_RB_GO:   state_next = ST_RB_WAIT;
      ST_RB_WAIT: if (div_done) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {high_bank_select, low_bank_select};
    div_divisor  = roms;
    unique case (state)
      ST_SW_GO: begin
        div_start    = 1'b1;
      end
      ST_FX_GO: begin
        div_start    = 1'b1;
        div_dividend = {high_bank_select, {LOW_SEL_W{1'b0}}};
      end
      ST_RB_GO: begin
        div_start    = 1'b1;
        div_dividend = DVD_W'(high_bank_select);
        div_divisor  = DIV_W'(rams);
      end
      default: begin
        div_start    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      m_tvalid         <= 1'b0;
      rom_bank_count   <= ROM_CNT_RESET;
      ram_bank_count   <= RAM_CNT_RESET;
      ram_present      <= 1'b0;
      ram_enabled      <= 1'b0;
      low_bank_select  <= LOW_SEL_W'(1);
      high_bank_select <= '0;
      advanced_mode    <= 1'b0;
      fixed_area_bank  <= '0;
      switch_area_bank <= ROM_BANK_W'(1);
      ram_bank         <= '0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROM_BANK_COUNT: rom_bank_count <= cfg_wdata[ROM_CNT_W-1:0];
          CFG_RAM_BANK_COUNT: ram_bank_count <= cfg_wdata[RAM_CNT_W-1:0];
          CFG_RAM_PRESENT:    ram_present    <= cfg_wdata[0];
          default: ;
        endcase
      end

      if (accept) begin
        m_tvalid <= 1'b1;
        unique case (reg_sel)
          REG_RAM_EN: ram_enabled <= (s_tdata[ADDR_W+3:ADDR_W] == RAM_EN_KEY);
          REG_LOW:    low_bank_select <= low_new;
          REG_HIGH:   high_bank_select <= s_tdata[ADDR_W+HIGH_SEL_W-1:ADDR_W];
          REG_MODE:   if (!mode_ignored) advanced_mode <= s_tdata[ADDR_W];
          default: ;
        endcase
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (div_done) begin
        unique case (state)
          ST_SW_WAIT: begin
            switch_area_bank <= div_rem;
            if (!advanced_mode) begin
              fixed_area_bank <= '0;
              ram_bank        <= '0;
            end
          end
          ST_FX_WAIT: fixed_area_bank <= div_rem;
          ST_RB_WAIT: ram_bank <= div_rem[RAM_BANK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_target <= res.target;
      out_phys   <= res.phys;
      out_wr     <= res.wr;
      out_wdata  <= res.wdata;
    end
  end

  assign m_tuser = out_target;
  assign m_tdata = {2'b00, out_wdata, out_wr, out_phys};

endmodule
